@@ hw/rtl/iumu_pkg.sv @@
`default_nettype none
package iumu_pkg;

   localparam int MAX_RANGES = 64;
   localparam int DOC_BITS   = 31;
   localparam int ID_WIDTH   = 31;
   localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);

   localparam logic [ID_WIDTH-1:0] ID_MASK = ID_WIDTH'((64'd1 << DOC_BITS) - 64'd1);

   typedef logic [ID_WIDTH-1:0] doc_id_type;

   typedef struct packed {
      doc_id_type in_begin;
      doc_id_type in_end;
      logic       in_valid;
      logic       in_last;
   } req_type;

   typedef struct packed {
      doc_id_type out_begin;
      doc_id_type out_end;
      logic       out_last;
      logic       out_empty;
      logic       out_overflow;
   } rsp_type;

   // one stored range as held by a sorter cell
   typedef struct packed {
      logic       vld;
      doc_id_type lo;
      doc_id_type hi;
   } range_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } chain_ctl_type;

   typedef enum logic {
      PH_LOAD,
      PH_DRAIN
   } phase_type;

endpackage
`default_nettype wire

@@ hw/rtl/interval_union_merge_unit.sv @@
// load: one range item per cycle into a 64-cell insertion-sort chain, no result
// drain: after the last item, one stored range leaves the chain head per cycle
//   while the output register is free
// first result: the last item moves the phase register to drain; an empty set then
//   registers its empty end item, others first load the head into the running range
// reset: clears cell valid bits, range count, overflow flag, phase and output valid
`default_nettype none
module interval_union_merge_unit (
   input  wire                clock,
   input  wire                reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  iumu_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output iumu_pkg::rsp_type  rsp_data
);
   import iumu_pkg::*;

   chain_ctl_type  ctl;
   range_type      new_range;
   range_type      cell_range [MAX_RANGES];
   logic           cell_before [MAX_RANGES];

   iumu_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .head      (cell_range[0]),
      .ctl       (ctl),
      .new_range (new_range),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      range_type left_range;
      range_type right_range;
      logic      left_before;

      if (i == 0) begin : g_head
         assign left_range  = new_range;
         assign left_before = 1'b0;
      end else begin : g_body
         assign left_range  = cell_range[i-1];
         assign left_before = cell_before[i-1];
      end

      if (i == MAX_RANGES - 1) begin : g_tail
         assign right_range = '{vld: 1'b0, lo: '0, hi: '0};
      end else begin : g_mid
         assign right_range = cell_range[i+1];
      end

      iumu_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_range   (new_range),
         .left_range  (left_range),
         .left_before (left_before),
         .right_range (right_range),
         .cur_range   (cell_range[i]),
         .new_before  (cell_before[i])
      );
   end

endmodule
`default_nettype wire

@@ hw/rtl/iumu_cell.sv @@
`default_nettype none
module iumu_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  iumu_pkg::chain_ctl_type  ctl,
   input  iumu_pkg::range_type      new_range,
   input  iumu_pkg::range_type      left_range,
   input  logic                     left_before,
   input  iumu_pkg::range_type      right_range,
   output iumu_pkg::range_type      cur_range,
   output logic                     new_before
);
   import iumu_pkg::*;

   logic        vld_ff, vld_in;
   doc_id_type  lo_ff, lo_in;
   doc_id_type  hi_ff, hi_in;
   range_type   range_in;

   assign cur_range = '{vld: vld_ff, lo: lo_ff, hi: hi_ff};

   // an empty cell sorts after everything
   assign new_before = !vld_ff || ({new_range.lo, new_range.hi} < {lo_ff, hi_ff});

   always_comb begin
      range_in = cur_range;
      if (ctl.shift) begin
         range_in = right_range;
      end else if (ctl.insert && new_before) begin
         // left neighbour also yields: take its entry, else the new item lands here
         range_in = left_before ? left_range : new_range;
      end
   end

   assign vld_in = range_in.vld;
   assign lo_in  = range_in.lo;
   assign hi_in  = range_in.hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

endmodule
`default_nettype wire

@@ hw/rtl/iumu_merge.sv @@
`default_nettype none
module iumu_merge (
   input  wire                      clock,
   input  wire                      reset,
   input  logic                     req_valid,
   input  iumu_pkg::req_type        req_data,
   output logic                     req_stall,
   input  iumu_pkg::range_type      head,
   output iumu_pkg::chain_ctl_type  ctl,
   output iumu_pkg::range_type      new_range,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output iumu_pkg::rsp_type        rsp_data
);
   import iumu_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic                 run_vld_ff, run_vld_in;
   doc_id_type           run_lo_ff, run_lo_in;
   doc_id_type           run_hi_ff, run_hi_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic req_acc, full, out_free, merge_hit, start_run;
   logic emit, shift, fin;

   assign req_acc   = req_valid && (phase_ff == PH_LOAD);
   assign full      = (count_ff == CNT_BITS'(MAX_RANGES));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // touching ranges stay apart: merge only when begin does not exceed running end
   assign merge_hit = (head.lo <= run_hi_ff);
   assign start_run = !run_vld_ff || !merge_hit;

   assign new_range = '{vld: 1'b1, lo: req_data.in_begin & ID_MASK,
                        hi: req_data.in_end & ID_MASK};

   // next state
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_LOAD: begin
            if (req_valid && req_data.in_last) phase_in = PH_DRAIN;
         end
         PH_DRAIN: begin
            if (fin) phase_in = PH_LOAD;
         end
         default: phase_in = PH_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      emit = 1'b0;
      shift = 1'b0;
      fin = 1'b0;
      req_stall = 1'b1;
      unique case (phase_ff)
         PH_LOAD: begin
            req_stall = 1'b0;
         end
         PH_DRAIN: begin
            if (head.vld) begin
               if (!start_run) begin
                  shift = 1'b1;
               end else if (!run_vld_ff) begin
                  shift = 1'b1;
               end else if (out_free) begin
                  emit  = 1'b1;
                  shift = 1'b1;
               end
            end else if (out_free) begin
               emit = 1'b1;
               fin  = 1'b1;
            end
         end
         default: req_stall = 1'b1;
      endcase
   end

   assign ctl.insert = req_acc && req_data.in_valid && !full;
   assign ctl.shift  = shift;

   always_comb begin
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      run_vld_in = run_vld_ff;
      run_lo_in  = run_lo_ff;
      run_hi_in  = run_hi_ff;
      if (fin) begin
         count_in   = '0;
         ovf_in     = 1'b0;
         run_vld_in = 1'b0;
      end else begin
         if (ctl.insert) count_in = count_ff + CNT_BITS'(1);
         if (req_acc && req_data.in_valid && full) ovf_in = 1'b1;
      end
      if (shift) begin
         if (start_run) begin
            run_vld_in = 1'b1;
            run_lo_in  = head.lo;
            run_hi_in  = head.hi;
         end else if (head.hi > run_hi_ff) begin
            run_hi_in = head.hi;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_begin    = run_vld_ff ? run_lo_ff : '0;
         rsp_in.out_end      = run_vld_ff ? run_hi_ff : '0;
         rsp_in.out_last     = fin;
         rsp_in.out_empty    = fin && !run_vld_ff;
         rsp_in.out_overflow = ovf_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         run_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         run_vld_ff   <= run_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_lo_ff <= run_lo_in;
      run_hi_ff <= run_hi_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ hw/rtl/iumu_checker.sv @@
`default_nettype none
module iumu_checker (
   input  wire                clock,
   input  wire                reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  iumu_pkg::req_type  req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  iumu_pkg::rsp_type  rsp_data
);

   // a held item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_empty |-> rsp_data.out_last)
      else $error("empty item not marked last");

   a_mid_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_last |-> !rsp_data.out_empty)
      else $error("empty flag on a non-final item");

   // the merge pass holds off new input
   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.in_last |=> req_stall)
      else $error("input taken during merge");

endmodule

bind interval_union_merge_unit iumu_checker u_iumu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

@@ tb/sv/interval_union_merge_checker.sv @@
`timescale 1ns / 1ps
module interval_union_merge_checker
   import iumu_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      ranges_due,
   output int      ranges_checked,
   output int      sets_merged,
   output int      sets_overflowed
);

   doc_id_type stored_lo [MAX_RANGES];
   doc_id_type stored_hi [MAX_RANGES];
   int         stored_count;
   logic       dropped_flag;
   rsp_type    merged_due [$];

   initial begin
      fail_count      = 0;
      ranges_checked  = 0;
      sets_merged     = 0;
      sets_overflowed = 0;
      stored_count    = 0;
      dropped_flag    = 1'b0;
   end

   assign ranges_due = merged_due.size();

   // store one item and, on the last mark, sort, sweep and queue the merged ranges
   task automatic predict_merge(input req_type item);
      doc_id_type  lo_s [MAX_RANGES];
      doc_id_type  hi_s [MAX_RANGES];
      doc_id_type  lo_t, hi_t, run_lo, run_hi;
      logic [31:0] run_next;
      int          n, i, j;
      rsp_type     r;
      if (item.in_valid) begin
         if (stored_count < MAX_RANGES) begin
            stored_lo[stored_count] = item.in_begin & ID_MASK;
            stored_hi[stored_count] = item.in_end & ID_MASK;
            stored_count++;
         end else begin
            dropped_flag = 1'b1;
         end
      end
      if (!item.in_last) return;
      sets_merged++;
      if (dropped_flag) sets_overflowed++;
      n = stored_count;
      if (n == 0) begin
         r.out_begin    = '0;
         r.out_end      = '0;
         r.out_last     = 1'b1;
         r.out_empty    = 1'b1;
         r.out_overflow = dropped_flag;
         merged_due = {merged_due, r};
      end else begin
         for (i = 0; i < n; i++) begin
            lo_s[i] = stored_lo[i];
            hi_s[i] = stored_hi[i];
         end
         // ascending begin, ties by ascending end
         for (i = 1; i < n; i++) begin
            lo_t = lo_s[i];
            hi_t = hi_s[i];
            j = i;
            while (j > 0 && (lo_s[j-1] > lo_t || (lo_s[j-1] == lo_t && hi_s[j-1] > hi_t))) begin
               lo_s[j] = lo_s[j-1];
               hi_s[j] = hi_s[j-1];
               j--;
            end
            lo_s[j] = lo_t;
            hi_s[j] = hi_t;
         end
         run_lo = lo_s[0];
         run_hi = hi_s[0];
         for (i = 1; i < n; i++) begin
            run_next = {1'b0, run_hi} + 32'd1;
            if (run_next > {1'b0, lo_s[i]}) begin
               if (hi_s[i] > run_hi) run_hi = hi_s[i];
            end else begin
               r.out_begin    = run_lo;
               r.out_end      = run_hi;
               r.out_last     = 1'b0;
               r.out_empty    = 1'b0;
               r.out_overflow = dropped_flag;
               merged_due = {merged_due, r};
               run_lo = lo_s[i];
               run_hi = hi_s[i];
            end
         end
         r.out_begin    = run_lo;
         r.out_end      = run_hi;
         r.out_last     = 1'b1;
         r.out_empty    = 1'b0;
         r.out_overflow = dropped_flag;
         merged_due = {merged_due, r};
      end
      stored_count = 0;
      dropped_flag = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         merged_due.delete();
         stored_count = 0;
         dropped_flag = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (merged_due.size() == 0) begin
               fail_count++;
               $display("%0t unexpected range: begin=%0d end=%0d last=%0b empty=%0b ovf=%0b",
                        $time, rsp_data.out_begin, rsp_data.out_end, rsp_data.out_last,
                        rsp_data.out_empty, rsp_data.out_overflow);
            end else begin
               want = merged_due.pop_front();
               ranges_checked++;
               if (want.out_begin !== rsp_data.out_begin || want.out_end !== rsp_data.out_end ||
                   want.out_last !== rsp_data.out_last || want.out_empty !== rsp_data.out_empty ||
                   want.out_overflow !== rsp_data.out_overflow) begin
                  fail_count++;
                  $display("%0t mismatch: expected begin=%0d end=%0d last=%0b empty=%0b ovf=%0b",
                           $time, want.out_begin, want.out_end, want.out_last,
                           want.out_empty, want.out_overflow);
                  $display("%0t           actual   begin=%0d end=%0d last=%0b empty=%0b ovf=%0b",
                           $time, rsp_data.out_begin, rsp_data.out_end, rsp_data.out_last,
                           rsp_data.out_empty, rsp_data.out_overflow);
               end
            end
         end
         if (req_valid && !req_stall) predict_merge(req_data);
      end
   end

endmodule

@@ tb/sv/interval_union_merge_unit_tb.sv @@
`timescale 1ns / 1ps
module interval_union_merge_unit_tb;
   import iumu_pkg::*;

   localparam doc_id_type TOP_ID = 31'h7FFF_FFFE;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count, ranges_due, ranges_checked, sets_merged, sets_overflowed;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent    = 0;

   always #1 clock = ~clock;

   interval_union_merge_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   interval_union_merge_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .ranges_due      (ranges_due),
      .ranges_checked  (ranges_checked),
      .sets_merged     (sets_merged),
      .sets_overflowed (sets_overflowed)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // called at a rising edge, returns at the edge that accepts the item
   task automatic send_item(input doc_id_type b, input doc_id_type e, input logic v,
                            input logic l);
      req_type d;
      d.in_begin = b;
      d.in_end   = e;
      d.in_valid = v;
      d.in_last  = l;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // one range drawn around a window so that overlaps and touches are frequent
   task automatic send_random_range(input int window, input doc_id_type base, input logic l);
      doc_id_type b, e, t;
      int         span;
      span = (window == 0) ? 256 : 4096;
      if (window == 3) begin
         b = doc_id_type'($urandom_range(TOP_ID, 0));
         e = doc_id_type'($urandom_range(TOP_ID, b));
      end else begin
         b = base + doc_id_type'($urandom_range(span - 1, 0));
         if (b > TOP_ID) b = TOP_ID;
         e = b + doc_id_type'($urandom_range(span / 8, 0));
         if (e > TOP_ID || e < b) e = TOP_ID;
      end
      if ($urandom_range(99) < 5) begin
         t = b;
         b = e;
         e = t;
      end
      send_item(b, e, 1'b1, l);
   endtask

   task automatic send_random_set(input logic force_overflow);
      int         window, size, pick, i;
      logic       carry_last;
      doc_id_type base;
      pick = $urandom_range(99);
      if (force_overflow || pick >= 96) size = $urandom_range(72, 65);
      else if (pick < 8) size = 0;
      else if (pick < 60) size = $urandom_range(6, 1);
      else if (pick < 85) size = $urandom_range(20, 7);
      else size = $urandom_range(64, 21);
      window = $urandom_range(3, 0);
      case (window)
         0: base = '0;
         1: base = TOP_ID - 31'd4095;
         default: base = doc_id_type'($urandom_range(TOP_ID - 31'd4095, 0));
      endcase
      if ($urandom_range(1) == 0 && window == 1) window = 0;
      if (window == 0 && base != 0) base = TOP_ID - 31'd255;
      carry_last = (size > 0) && ($urandom_range(1) == 1);
      for (i = 0; i < size; i++) begin
         // stray markers without the last mark are ignored by the block
         if ($urandom_range(99) < 8) begin
            send_item(doc_id_type'($urandom), doc_id_type'($urandom), 1'b0, 1'b0);
         end
         send_random_range(window, base, carry_last && (i == size - 1));
      end
      if (!carry_last) send_item(doc_id_type'($urandom), doc_id_type'($urandom), 1'b0, 1'b1);
   endtask

   // one edge first so that the last accepted item is already predicted
   task automatic wait_drained;
      @(posedge clock);
      while (ranges_due != 0) @(posedge clock);
   endtask

   initial begin
      int phase, sets_in_phase, target;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 7;
      recv_idle_pct = 49;
      // empty set, then a single point range alone
      send_item('0, '0, 1'b0, 1'b1);
      send_item('0, '0, 1'b1, 1'b1);
      // full span swallowing a top-end point
      send_item(TOP_ID, TOP_ID, 1'b1, 1'b0);
      send_item(31'd0, TOP_ID, 1'b1, 1'b1);
      // touching ranges stay separate
      send_item(31'd10, 31'd20, 1'b1, 1'b0);
      send_item(31'd21, 31'd30, 1'b1, 1'b0);
      send_item(31'd5, 31'd9, 1'b1, 1'b0);
      send_item(31'h2AAA_AAAA, 31'h5555_5555, 1'b1, 1'b0);
      send_item('0, '0, 1'b0, 1'b1);
      // equal begins, containment and reversed ranges
      send_item(31'd100, 31'd200, 1'b1, 1'b0);
      send_item(31'd150, 31'd180, 1'b1, 1'b0);
      send_item(31'd150, 31'd120, 1'b1, 1'b0);
      send_item(31'd100, 31'd90, 1'b1, 1'b0);
      send_item(31'd201, 31'd201, 1'b1, 1'b0);
      send_item(31'd199, 31'd300, 1'b1, 1'b1);
      // ignored bare marker, then a reversed range alone
      send_item(31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 1'b0);
      send_item(31'd7, 31'd3, 1'b1, 1'b1);
      // top end touching and overlapping
      send_item(TOP_ID - 31'd1, TOP_ID - 31'd1, 1'b1, 1'b0);
      send_item(TOP_ID, TOP_ID, 1'b1, 1'b0);
      send_item(TOP_ID - 31'd5, TOP_ID - 31'd1, 1'b1, 1'b1);
      req_valid <= 1'b0;
      wait_drained();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 7;  recv_idle_pct = 49; end
            1: begin send_idle_pct = 49; recv_idle_pct = 7;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         target = items_sent + 145;
         sets_in_phase = 0;
         while (items_sent < target) begin
            send_random_set(sets_in_phase == 2);
            sets_in_phase++;
         end
         // hold off until the block has handed over every merged range
         req_valid <= 1'b0;
         wait_drained();
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (150) @(posedge clock);
      $display("run covered %0d items in %0d sets, %0d with dropped ranges",
               items_sent, sets_merged, sets_overflowed);
      $display("%0d merged ranges compared, %0d failures", ranges_checked, fail_count);
      if (fail_count == 0 && ranges_due == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
